>>> rtl/mlt_pkg.sv
package mlt_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 64;
    localparam int PORT_COUNT  = 16;
    localparam int TIME_BITS   = 16;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 4;
    localparam int TMO_W   = 15;
    localparam int OP_W    = 2;
    localparam int CNT_W   = 7;

    localparam logic [TMO_W-1:0] TMO_RESET = 15'd300;
    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;

    // Comparison width for age against timeout
    localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

    // Port range limit, one bit wider than the port field
    localparam logic [PORT_W:0] PORT_LIM = (PORT_W + 1)'(PORT_COUNT);

    // Removal count tree: groups of eight cells, then a sum over the groups
    localparam int GROUP    = 8;
    localparam int N_GROUPS = (TABLE_DEPTH + GROUP - 1) / GROUP;
    localparam int PAD_W    = N_GROUPS * GROUP;
    localparam int GRP_W    = $clog2(GROUP + 1);
    localparam int SUM_W    = $clog2(TABLE_DEPTH + 1);
    localparam int SAT_W    = (SUM_W > CNT_W) ? SUM_W : CNT_W;

    // Beat widths, rounded up to whole bytes
    localparam int IN_W  = 56;
    localparam int OUT_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 probe;
        logic                 apply;
        logic [OP_W-1:0]      op;
        logic                 ins_ok;
        logic                 any_hit;
        logic [MAC_W-1:0]     mac;
        logic [PORT_W-1:0]    port;
        logic [TIME_BITS-1:0] now;
        logic [TMO_W-1:0]     timeout;
    } t_cell_ctrl;

endpackage

>>> rtl/mlt_cell.sv
module mlt_cell
    import mlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_free_before,
    output logic              o_free_before,
    input  logic [PORT_W-1:0] i_port_acc,
    output logic [PORT_W-1:0] o_port_acc,
    output logic              o_hit,
    output logic              o_exp
);

    logic                 r_valid;
    logic                 r_hit;
    logic                 r_exp;
    logic [MAC_W-1:0]     r_mac;
    logic [PORT_W-1:0]    r_port;
    logic [TIME_BITS-1:0] r_seen;

    logic [TIME_BITS-1:0] age;
    logic                 age_ge;
    logic                 is_lookup;
    logic                 is_insert;
    logic                 is_tick;
    logic                 sel_ins;

    // Age of the entry against the current time, wrapping
    assign age       = i_ctrl.now - r_seen;
    assign age_ge    = CMP_W'(age) >= CMP_W'(i_ctrl.timeout);
    assign is_lookup = i_ctrl.op == OP_LOOKUP;
    assign is_insert = i_ctrl.op == OP_INSERT;
    assign is_tick   = i_ctrl.op == OP_TICK;

    // This cell takes an insert if it holds the address, or if it is the
    // lowest free cell and no cell holds the address.
    assign sel_ins = i_ctrl.apply && is_insert && i_ctrl.ins_ok &&
                     (r_hit || (!i_ctrl.any_hit && !r_valid && !i_free_before));

    // Neighbour links: free-cell priority and the matched port
    assign o_free_before = i_free_before | ~r_valid;
    assign o_port_acc    = i_port_acc | (r_hit ? r_port : '0);
    assign o_hit         = r_hit;
    assign o_exp         = r_exp;

    // Valid bit and probe flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_exp   <= 1'b0;
        end else begin
            if (i_ctrl.probe) begin
                r_hit <= r_valid && (r_mac == i_ctrl.mac) && (is_lookup || is_insert);
                r_exp <= r_valid && is_tick && age_ge;
            end
            if (sel_ins) begin
                r_valid <= 1'b1;
            end else if (i_ctrl.apply && is_tick && r_exp) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (sel_ins) begin
            r_mac  <= i_ctrl.mac;
            r_port <= i_ctrl.port;
            r_seen <= i_ctrl.now;
        end else if (i_ctrl.apply && is_lookup && r_hit) begin
            r_seen <= i_ctrl.now;
        end
    end

endmodule

>>> rtl/mlt_count.sv
module mlt_count
    import mlt_pkg::*;
(
    input  logic                   i_clk,
    input  logic [TABLE_DEPTH-1:0] i_bits,
    output logic [SUM_W-1:0]       o_count
);

    logic [PAD_W-1:0] padded;
    logic [GRP_W-1:0] n_grp [N_GROUPS];
    logic [GRP_W-1:0] r_grp [N_GROUPS];
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_sum;

    assign padded = PAD_W'(i_bits);

    // First stage: population count of each group of eight
    always_comb begin
        for (int g = 0; g < N_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GROUP; b++) begin
                n_grp[g] = n_grp[g] + GRP_W'(padded[g * GROUP + b]);
            end
        end
    end

    // Second stage: sum of the group counts
    always_comb begin
        n_sum = '0;
        for (int g = 0; g < N_GROUPS; g++) begin
            n_sum = n_sum + SUM_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_sum <= n_sum;
    end

    assign o_count = r_sum;

endmodule

>>> rtl/mac_learning_table_with_aging.sv
// A result beat is registered once its input beat has passed the compare, act and
// sum states; a new item is taken only while idle or as the last result is loaded.
// The cells are probed in the compare state and updated in the act state; the
// removal count passes a two-stage adder tree before the result register.
// Reset (synchronous, active low) clears every entry's valid bit and the time
// at once, and sets the aging timeout to 300; there is no clearing pass.
module mac_learning_table_with_aging
    import mlt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TMO_W-1:0] i_cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [47:0] mac_addr, [51:48] port, [55:52] zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] found, [4:1] port_out, [11:5] removed_count, [12] table_full, [15:13] zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_ACT,
        S_SUM,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [MAC_W-1:0]     r_mac;
    logic [PORT_W-1:0]    r_port_in;
    logic [TIME_BITS-1:0] r_now;
    logic [TMO_W-1:0]     r_timeout;
    logic                 r_found;
    logic [PORT_W-1:0]    r_port_res;
    logic                 r_full;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_cell_ctrl             ctrl;
    logic                   free_chain [TABLE_DEPTH+1];
    logic [PORT_W-1:0]      port_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] exp_vec;
    logic                   any_hit;
    logic                   ins_ok;
    logic                   in_acc;
    logic                   out_load;
    logic [SUM_W-1:0]       sum;
    logic [CNT_W-1:0]       removed;
    logic [OP_W-1:0]        in_op;

    assign in_op    = s_axis_tuser;
    assign any_hit  = |hit_vec;
    assign ins_ok   = {1'b0, r_port_in} < PORT_LIM;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE) || out_load;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // Broadcast to the cell row
    assign ctrl.probe   = r_state == S_CMP;
    assign ctrl.apply   = r_state == S_ACT;
    assign ctrl.op      = r_op;
    assign ctrl.ins_ok  = ins_ok;
    assign ctrl.any_hit = any_hit;
    assign ctrl.mac     = r_mac;
    assign ctrl.port    = r_port_in;
    assign ctrl.now     = r_now;
    assign ctrl.timeout = r_timeout;

    assign free_chain[0] = 1'b0;
    assign port_chain[0] = '0;

    // Row of table cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        mlt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_free_before (free_chain[i]),
            .o_free_before (free_chain[i+1]),
            .i_port_acc    (port_chain[i]),
            .o_port_acc    (port_chain[i+1]),
            .o_hit         (hit_vec[i]),
            .o_exp         (exp_vec[i])
        );
    end

    // Removal count over the expired flags
    mlt_count u_count (
        .i_clk   (i_clk),
        .i_bits  (exp_vec),
        .o_count (sum)
    );

    assign removed = (SAT_W'(sum) > SAT_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);

    // Sequencer, time, timeout and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_timeout   <= TMO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {3'b000, r_full, removed, r_port_res, r_found};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && in_op == OP_TICK) begin
                r_now <= r_now + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (in_acc) begin
                        r_state <= S_CMP;
                    end else if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item registers and lookup/insert outcome
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= in_op;
            r_mac     <= s_axis_tdata[47:0];
            r_port_in <= s_axis_tdata[51:48];
        end
        if (r_state == S_ACT) begin
            r_found    <= (r_op == OP_LOOKUP) && any_hit;
            r_port_res <= (r_op == OP_LOOKUP) ? port_chain[TABLE_DEPTH] : '0;
            r_full     <= (r_op == OP_INSERT) && ins_ok && !any_hit &&
                          !free_chain[TABLE_DEPTH];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // No address is held by more than one entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(hit_vec))
        else $error("address matched in more than one entry");

    // A dropped insert never reports a match or removals
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[12]) |-> (r_out_data[11:0] == 12'd0))
        else $error("table full flagged together with other results");

    // A tick advances the time by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_TICK) |=> (r_now == $past(r_now) + 1'b1))
        else $error("time did not advance on a tick");

    // Input is only taken when the row is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == S_IDLE || r_state == S_DONE))
        else $error("item accepted while the cell row is busy");

endmodule
